/* sv/prf_pkg.sv */
// Package for the polynomial root finder: widths, status codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prf_pkg;
  localparam int unsigned COEFF_W = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CF  = 6;
  // widest unsaturated scaled coefficient: 5*c5 shifted by up to 30 fraction bits
  localparam int unsigned TERM_W  = 50;

  // x/1000 as ((|x| >> 3) * ceil(2^36/125)) >> 36, exact for |x| <= 2^31
  localparam logic signed [31:0] DIV1K_MUL = 32'sd549755814;
  localparam int unsigned        DIV1K_SH  = 36;

  typedef enum logic [1:0] {
    ST_CONVERGED  = 2'd0,
    ST_LIMIT      = 2'd1,
    ST_ZERO_SLOPE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_C5  = 3'd0,
    REG_C4  = 3'd1,
    REG_C3  = 3'd2,
    REG_C2  = 3'd3,
    REG_C1  = 3'd4,
    REG_C0  = 3'd5,
    REG_TOL = 3'd6,
    REG_MTH = 3'd7
  } reg_idx_t;

  // Shared unit operations
  typedef enum logic [1:0] {
    OP_MULSH = 2'd0,   // sat(floor(a*b / 2^F))
    OP_ADD   = 2'd1,   // sat(a + b)
    OP_SUB   = 2'd2,   // sat(a - b)
    OP_DIV1K = 2'd3    // a / 1000, truncated toward zero
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat64(input logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    begin
      mx = 66'sd2147483647;
      mn = -66'sd2147483648;
      if (v > mx) sat64 = DATA_W'(mx);
      else if (v < mn) sat64 = DATA_W'(mn);
      else sat64 = v[DATA_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

/* sv/prf_if.sv */
// Valid/ready stream interface carrying a parameterised payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface prf_stream_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/prf_alu.sv */
// Shared arithmetic unit: saturating fixed-point multiply, add, subtract, x/1000.
// Uses prf_pkg. One 32x32 multiplier; the result is registered when start is high.
`timescale 1ns / 1ps
`default_nettype none
module prf_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire prf_pkg::alu_ctl_t                    ctl,
  input  wire logic signed [31:0]                   a,
  input  wire logic signed [prf_pkg::TERM_W-1:0]    b,
  output logic signed [31:0]                        y_r
);
  logic signed [32:0] amag;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] recip;
  logic signed [65:0] ext;
  logic signed [31:0] y_nxt;

  always_comb begin
    amag = a[31] ? -33'(a) : 33'(a);
    ma = a;
    mb = b[31:0];
    // reciprocal multiply for the finite-difference step
    if (ctl.op == prf_pkg::OP_DIV1K) begin
      ma = {3'b000, amag[31:3]};
      mb = prf_pkg::DIV1K_MUL;
    end
    prod  = ma * mb;
    recip = prod >>> prf_pkg::DIV1K_SH;
    ext   = '0;
    case (ctl.op)
      prf_pkg::OP_MULSH: ext = 66'(prod) >>> FRAC_BITS;  // arithmetic shift is floor
      prf_pkg::OP_ADD:   ext = 66'(a) + 66'(b);
      prf_pkg::OP_SUB:   ext = 66'(a) - 66'(b);
      prf_pkg::OP_DIV1K: ext = a[31] ? -66'(recip) : 66'(recip);
      default:           ext = '0;
    endcase
    y_nxt = prf_pkg::sat64(ext);
  end

  always_ff @(posedge clk) begin
    if (ctl.start) y_r <= y_nxt;
  end
endmodule
`default_nettype wire

/* sv/prf_div.sv */
// Radix-2 restoring divider: sat(trunc(n * 2^F / d)), one quotient bit per cycle.
// Uses prf_pkg. Takes 32+FRAC_BITS steps, then pulses done with the registered quotient.
`timescale 1ns / 1ps
`default_nettype none
module prf_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done_r,
  output logic signed [31:0]      quo_r
);
  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]  dvd_r, dvd_nxt;
  logic [31:0]    dsr_r;
  logic [32:0]    rem_r, rem_nxt;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, neg_r;
  logic [32:0]    trial;
  logic [32:0]    nmag;
  logic [NW-1:0]  anum;
  logic [31:0]    aden;
  logic signed [65:0] sq;

  always_comb begin
    nmag = num[31] ? 33'(-33'(num)) : 33'(num);
    anum = NW'(nmag) << FRAC_BITS;
    aden = den[31] ? 32'(-33'(den)) : 32'(den);
    trial   = {rem_r[31:0], dvd_r[NW-1]} - {1'b0, dsr_r};
    rem_nxt = trial[32] ? {rem_r[31:0], dvd_r[NW-1]} : trial;
    dvd_nxt = {dvd_r[NW-2:0], ~trial[32]};
    sq = neg_r ? -66'(dvd_r) : 66'(dvd_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        dvd_r  <= anum;
        dsr_r  <= aden;
        rem_r  <= '0;
        neg_r  <= num[31] ^ den[31];
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quo_r  <= prf_pkg::sat64(sq);
        end else begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_nxt;
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sv/polynomial_root_finder.sv */
// Top level of the polynomial root finder: registers, sequencer, shared units.
// Uses prf_pkg, prf_stream_if, prf_alu, prf_div.
`timescale 1ns / 1ps
`default_nettype none
// Newton-Raphson root search on a degree-5 integer polynomial in signed
// Q16.16. One request is taken at a time; in_ready is low while it runs.
// Each iteration runs Horner passes on the shared multiply/add unit (a
// multiply, an add and a write-back state per step) and up to two divisions
// on the bit-serial divider, whose quotient is Q16.16 when FRAC_BITS is 16.
// A request ends on a zero slope or on convergence, else after MAX_ITER
// iterations.
module polynomial_root_finder #(
  parameter int unsigned MAX_ITER  = 26,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  prf_stream_if.sink       in_s,
  prf_stream_if.source     out_s
);
  localparam int unsigned IW = $clog2(MAX_ITER + 1);
  localparam int unsigned TW = prf_pkg::TERM_W;

  typedef enum logic [4:0] {
    S_IDLE, S_IT, S_H_INIT, S_H_MUL, S_H_ADD, S_H_DONE,
    S_HDIV, S_HDIVW, S_X2, S_X2W, S_DY, S_DYW, S_SDIV, S_SDIVW,
    S_QDIV, S_QDIVW, S_X1, S_X1W, S_TEST, S_OUT
  } state_t;

  typedef enum logic [1:0] {P_FX, P_DER, P_F2, P_F1} pass_t;

  logic signed [15:0] cf_r [prf_pkg::NUM_CF];
  logic [15:0] tol_r;
  logic        mth_r;

  state_t state_r;
  pass_t  pass_r;
  logic [2:0] hi_r;
  logic [IW-1:0] it_r;
  logic signed [31:0] x_r, x2_r, fx_r, s_r, acc_r, dx_r;
  logic signed [31:0] a_op;
  logic signed [TW-1:0] b_op;
  prf_pkg::alu_ctl_t ctl;
  logic signed [31:0] alu_y;
  logic div_go, div_done;
  logic signed [31:0] div_n, div_d, div_q;
  logic signed [31:0] root_r;
  logic [1:0] st_r;
  logic [4:0] itout_r;
  logic ovalid_r;
  logic signed [31:0] hx, kcur, f1abs;
  logic signed [TW-1:0] kterm;
  logic [2:0] hn;

  // coefficient of current Horner step, scaled to fixed point
  always_comb begin
    logic signed [18:0] k;
    k = 19'(cf_r[hi_r]);
    if (pass_r == P_DER) k = k * 19'(5 - hi_r);
    kterm = TW'(k) <<< FRAC_BITS;
    kcur = prf_pkg::sat64(66'(kterm));
    hn = (pass_r == P_DER) ? 3'd4 : 3'd5;
    hx = (pass_r == P_F2) ? x2_r : (pass_r == P_F1) ? root_r : x_r;
    f1abs = acc_r[31] ? prf_pkg::sat64(-66'(acc_r)) : acc_r;
  end

  always_comb begin
    ctl.start = 1'b0;
    ctl.op = prf_pkg::OP_ADD;
    a_op = acc_r;
    b_op = kterm;
    unique case (state_r)
      S_H_MUL: begin ctl.start = 1'b1; ctl.op = prf_pkg::OP_MULSH; b_op = TW'(hx); end
      S_H_ADD: begin ctl.start = 1'b1; a_op = alu_y; end
      S_HDIV:  begin ctl.start = 1'b1; ctl.op = prf_pkg::OP_DIV1K; a_op = x_r; end
      S_X2:    begin ctl.start = 1'b1; a_op = x_r; b_op = TW'(alu_y); end
      S_DY:    begin
        ctl.start = 1'b1; ctl.op = prf_pkg::OP_SUB; a_op = acc_r; b_op = TW'(fx_r);
      end
      S_X1:    begin
        ctl.start = 1'b1; ctl.op = prf_pkg::OP_SUB; a_op = x_r; b_op = TW'(div_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_go = (state_r == S_SDIV) || (state_r == S_QDIV);
    div_n = (state_r == S_SDIV) ? acc_r : fx_r;
    div_d = (state_r == S_SDIV) ? dx_r : s_r;
  end

  prf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .ctl(ctl), .a(a_op), .b(b_op), .y_r(alu_y)
  );

  prf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go),
    .num(div_n), .den(div_d), .done_r(div_done), .quo_r(div_q)
  );

  assign in_s.ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_s.valid = ovalid_r;
  assign out_s.data  = {root_r, st_r, itout_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < prf_pkg::NUM_CF; i++) cf_r[i] <= '0;
      tol_r    <= 16'd66;
      mth_r    <= 1'b0;
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == prf_pkg::REG_TOL) tol_r <= cfg_wdata;
        else if (cfg_index == prf_pkg::REG_MTH) mth_r <= cfg_wdata[0];
        else if (cfg_index < 3'(prf_pkg::NUM_CF)) cf_r[cfg_index] <= cfg_wdata;
      end
      if (ovalid_r && out_s.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_s.valid && in_s.ready) begin
          x_r <= in_s.data;
          it_r <= '0;
          state_r <= S_IT;
        end
        S_IT: begin
          it_r <= it_r + 1'b1;
          pass_r <= P_FX;
          hi_r <= 3'd0;
          state_r <= S_H_INIT;
        end
        S_H_INIT: begin
          acc_r <= kcur;
          hi_r <= 3'd1;
          state_r <= S_H_MUL;
        end
        S_H_MUL: state_r <= S_H_ADD;
        S_H_ADD: state_r <= S_H_DONE;
        S_H_DONE: begin
          acc_r <= alu_y;
          if (hi_r == hn) begin
            unique case (pass_r)
              P_FX: begin
                fx_r <= alu_y;
                if (mth_r) state_r <= S_HDIV;
                else begin pass_r <= P_DER; hi_r <= 3'd0; state_r <= S_H_INIT; end
              end
              P_DER: begin
                s_r <= alu_y;
                state_r <= (alu_y == 0) ? S_TEST : S_QDIV;
              end
              P_F2: state_r <= S_DY;
              P_F1: state_r <= S_TEST;
              default: ;
            endcase
          end else begin
            hi_r <= hi_r + 3'd1;
            state_r <= S_H_MUL;
          end
        end
        S_HDIV: state_r <= S_HDIVW;
        S_HDIVW: state_r <= S_X2;
        S_X2: state_r <= S_X2W;
        S_X2W: begin
          x2_r <= alu_y;
          dx_r <= 32'(66'(alu_y) - 66'(x_r));
          if (alu_y == x_r) begin s_r <= '0; state_r <= S_TEST; end
          else begin pass_r <= P_F2; hi_r <= 3'd0; state_r <= S_H_INIT; end
        end
        S_DY: state_r <= S_DYW;
        S_DYW: begin acc_r <= alu_y; state_r <= S_SDIV; end
        S_SDIV: state_r <= S_SDIVW;
        S_SDIVW: if (div_done) begin
          s_r <= div_q;
          state_r <= (div_q == 0) ? S_TEST : S_QDIV;
        end
        S_QDIV: state_r <= S_QDIVW;
        S_QDIVW: if (div_done) state_r <= S_X1;
        S_X1: state_r <= S_X1W;
        S_X1W: begin
          root_r <= alu_y;
          pass_r <= P_F1; hi_r <= 3'd0; state_r <= S_H_INIT;
        end
        S_TEST: begin
          itout_r <= 5'(it_r);
          if (s_r == 0 && pass_r != P_F1) begin
            root_r <= x_r; st_r <= prf_pkg::ST_ZERO_SLOPE; state_r <= S_OUT;
          end else if (f1abs < $signed({16'd0, tol_r})) begin
            st_r <= prf_pkg::ST_CONVERGED; state_r <= S_OUT;
          end else if (32'(it_r) >= MAX_ITER) begin
            st_r <= prf_pkg::ST_LIMIT; state_r <= S_OUT;
          end else begin
            x_r <= root_r; state_r <= S_IT;
          end
        end
        S_OUT: if (!ovalid_r) begin ovalid_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/prf_checker.sv */
// Port-level checker for the polynomial root finder, bound to the top level.
// Depends on polynomial_root_finder ports only.
`timescale 1ns / 1ps
`default_nettype none
module prf_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [38:0] out_data
);
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("request taken while busy");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready with result pending");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data[6:5] != 2'd3) else $error("bad status");
  a_iter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data[4:0] != 5'd0) else $error("zero iteration count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
endmodule

bind polynomial_root_finder prf_port_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_s.valid), .in_ready(in_s.ready),
  .out_valid(out_s.valid), .out_ready(out_s.ready), .out_data(out_s.data)
);
`default_nettype wire

/* tb/prf_checker.sv */
// Checker for the polynomial root finder: watches the request and result
// channels, predicts each result from its own model of the search and compares.
// Depends on prf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prf_checker #(
  parameter int unsigned MAX_ITER  = 26,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [38:0] out_data,
  output int               errors,
  output int               pending
);
  typedef struct packed {
    logic signed [31:0] root;
    prf_pkg::status_t   status;
    logic [4:0]         iters;
  } root_result_t;

  typedef logic signed [63:0] s64_t;

  s64_t         coeff[6];
  logic [15:0]  tol;
  logic         use_fd;
  root_result_t expected_roots[$];

  function automatic s64_t clamp32(input s64_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor division by 2^F: arithmetic shift does exactly that
  function automatic s64_t eval_horner(input s64_t k[6], input int n, input s64_t x);
    s64_t acc;
    acc = clamp32(k[0] <<< FRAC_BITS);
    for (int i = 1; i < n; i++) begin
      acc = clamp32((acc * x) >>> FRAC_BITS);
      acc = clamp32(acc + (k[i] <<< FRAC_BITS));
    end
    return acc;
  endfunction

  function automatic root_result_t search_root(input s64_t x0);
    root_result_t r;
    s64_t x, fx, s, q, x1, f1, x2, dx, dy;
    s64_t dk[6];
    x = x0;
    r.root = x0[31:0];
    r.status = prf_pkg::ST_LIMIT;
    r.iters = '0;
    dk[0] = 5 * coeff[0]; dk[1] = 4 * coeff[1]; dk[2] = 3 * coeff[2];
    dk[3] = 2 * coeff[3]; dk[4] = coeff[4]; dk[5] = 0;
    for (int k = 1; k <= MAX_ITER; k++) begin
      fx = eval_horner(coeff, 6, x);
      r.iters = 5'(k);
      if (!use_fd) begin
        s = eval_horner(dk, 5, x);
      end else begin
        x2 = clamp32(x + x / 1000);
        dx = x2 - x;
        dy = clamp32(eval_horner(coeff, 6, x2) - fx);
        s = (dx == 0) ? 0 : clamp32((dy <<< FRAC_BITS) / dx);
      end
      if (s == 0) begin
        r.status = prf_pkg::ST_ZERO_SLOPE;
        r.root = x[31:0];
        break;
      end
      q = clamp32((fx <<< FRAC_BITS) / s);
      x1 = clamp32(x - q);
      f1 = eval_horner(coeff, 6, x1);
      if (f1 < 0) f1 = -f1;
      r.root = x1[31:0];
      if (f1 < s64_t'(tol)) begin
        r.status = prf_pkg::ST_CONVERGED;
        break;
      end
      x = x1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    root_result_t got, want;
    if (!rst_n) begin
      foreach (coeff[i]) coeff[i] = 0;
      tol = 16'd66;
      use_fd = 1'b0;
      errors = 0;
      expected_roots.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (prf_pkg::reg_idx_t'(cfg_index))
          prf_pkg::REG_TOL: tol = cfg_wdata;
          prf_pkg::REG_MTH: use_fd = cfg_wdata[0];
          default: coeff[cfg_index] = s64_t'($signed(cfg_wdata));
        endcase
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_roots.size() == 0) begin
          $error("result with no request outstanding: %h", out_data);
          errors++;
        end else begin
          want = expected_roots.pop_front();
          if (got.root !== want.root) begin
            $error("root: expected %0d, got %0d", want.root, got.root);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.iters !== want.iters) begin
            $error("iterations: expected %0d, got %0d", want.iters, got.iters);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_roots.push_back(search_root(s64_t'($signed(in_data))));
      pending = expected_roots.size();
    end
  end
endmodule
`default_nettype wire

/* tb/polynomial_root_finder_test.sv */
// Top of the root finder testbench: clock, reset, configuration phases,
// requests and result back-pressure. Uses prf_pkg, prf_stream_if, prf_checker.
`timescale 1ns / 1ps
`default_nettype none
module polynomial_root_finder_test;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  int          errors, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;

  prf_stream_if #(.W(32)) req_ch ();
  prf_stream_if #(.W(39)) res_ch ();

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  always #4 clk = ~clk;

  polynomial_root_finder dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_s(req_ch.sink), .out_s(res_ch.source)
  );

  prf_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(req_ch.valid), .in_ready(req_ch.ready),
    .in_data(req_ch.data), .out_valid(res_ch.valid), .out_ready(res_ch.ready),
    .out_data(res_ch.data), .errors(errors), .pending(pending)
  );

  always @(posedge clk)
    res_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input prf_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_poly(input logic [15:0] c5, c4, c3, c2, c1, c0,
                           input logic [15:0] tl, input logic fd);
    write_reg(prf_pkg::REG_C5, c5); write_reg(prf_pkg::REG_C4, c4);
    write_reg(prf_pkg::REG_C3, c3); write_reg(prf_pkg::REG_C2, c2);
    write_reg(prf_pkg::REG_C1, c1); write_reg(prf_pkg::REG_C0, c0);
    write_reg(prf_pkg::REG_TOL, tl); write_reg(prf_pkg::REG_MTH, {15'd0, fd});
    cfg_we <= 1'b0;
  endtask

  // valid stays up after acceptance only until the next request or drain
  task automatic send_estimate(input logic [31:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= x;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // wait for all results, then past the block's tail before touching registers
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_estimate();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(20)) - 10) <<< 16 | 32'($urandom_range(65535));
      2: return 32'($signed($urandom_range(2000)) - 1000) <<< 10;
      default: return 32'($signed($urandom_range(200)) - 100) <<< 16;
    endcase
  endfunction

  function automatic logic [15:0] rand_coeff();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 16'($signed($urandom_range(20)) - 10);
      default: return 16'($signed($urandom_range(6)) - 3);
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset settings: zero polynomial gives zero slope at once
    send_estimate(32'h0001_0000);
    drain();
    // x^2 - 2, analytic
    load_poly(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'hFFFE, 16'd66, 1'b0);
    send_estimate(32'h0001_0000); send_estimate(32'h7FFF_FFFF);
    send_estimate(32'h8000_0000); send_estimate(32'h0000_0000);
    send_estimate(32'hFFFF_FFFF);
    drain();
    // same, finite difference: x == 0 and tiny x give zero step
    write_reg(prf_pkg::REG_MTH, 16'd1);
    cfg_we <= 1'b0;
    send_estimate(32'h0000_0000); send_estimate(32'h0000_0001);
    send_estimate(32'h0003_0000); send_estimate(32'hFFFD_0000);
    send_estimate(32'h8000_0000); send_estimate(32'h7FFF_FFFF);
    drain();
    // extreme coefficients, zero tolerance never converges
    load_poly(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 1'b0);
    send_estimate(32'h0001_0000); send_estimate(32'hFFFF_0000);
    drain();
    load_poly(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
    send_estimate(32'h0002_0000); send_estimate(32'h8000_0000);
    // x^2 + 1 has no root: runs to the limit
    drain();
    load_poly(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd1, 1'b0);
    send_estimate(32'h0000_8000); send_estimate(32'h0005_0000);
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      load_poly(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
                rand_coeff(),
                (ph % 5 == 0) ? 16'd1 : (ph % 5 == 1) ? 16'hFFFF : 16'($urandom_range(1, 65535)),
                ph[0] ^ ph[2]);
      repeat (24) send_estimate(rand_estimate());
      drain();
    end

    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #150ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
